>>> sv/aosf_pkg.sv
// Package for the ADC oversampling scan filter.
// Field widths, register indexes and reset values shared by the RTL and the checker.
// No dependencies.
`default_nettype none

package aosf_pkg;

   // payload field widths
   localparam int SAMPLE_W  = 12;
   localparam int VALUE_W   = 16;
   localparam int SLOT_W    = 4;
   localparam int CHAN_W    = 5;

   // stream bus widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // internal state widths
   localparam int ACC_W     = 28;
   localparam int CNT_W     = 17;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;
   localparam int CFG_W      = 5;

   // scan table geometry
   localparam int MAX_SLOTS      = 16;
   localparam int SLOTS_PER_WORD = 8;

   // depth limits
   localparam logic [CFG_W-1:0] DEPTH_MIN = 5'd1;
   localparam logic [CFG_W-1:0] DEPTH_MAX = 5'd16;

   // reset values of the configuration registers
   localparam logic [CFG_W-1:0] DEPTH_RST = 5'd4;
   localparam logic [CFG_W-1:0] EXTRA_RST = 5'd0;
   localparam logic [CFG_W-1:0] COUNT_RST = 5'd1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_DEPTH   = 3'd0,
      CFG_EXTRA   = 3'd1,
      CFG_COUNT   = 3'd2,
      CFG_CHAN_LO = 3'd3,
      CFG_CHAN_HI = 3'd4
   } cfg_index_type;

endpackage

`default_nettype wire

>>> sv/adc_oversample_scan_filter.sv
// Top level of the ADC oversampling scan filter: accumulator, scan sequencer, result register.
// Depends on aosf_pkg.
//
// The block takes one 12-bit sample per transaction and produces one result transaction for
// each sample, so it sustains one sample per clock cycle while the output is not stalled.
// Accumulation, the shift and the slot advance all happen in the cycle a sample is accepted;
// the result then sits in the output register, and the response is valid in the next cycle.
// A new sample is accepted whenever the output register is empty or is being emptied in the
// same cycle. Every 2^depth samples the response carries a filtered value (tuser high) for
// the slot that finished, tlast marks the end of a scan, and every response carries the
// hardware channel to convert next. Configuration writes are taken in any cycle.
`default_nettype none

module adc_oversample_scan_filter (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [aosf_pkg::REQ_DATA_W-1:0]     req_tdata,   // [11:0] sample
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [aosf_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [15:0] result_value,
                                                            // [19:16] result_slot,
                                                            // [24:20] next_channel
   output logic                                rsp_tuser,   // [0] result_valid
   output logic                                rsp_tlast,   // scan_done
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [aosf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [aosf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int PAD_W = aosf_pkg::RSP_DATA_W - aosf_pkg::VALUE_W - aosf_pkg::SLOT_W
                          - aosf_pkg::CHAN_W;

   // configuration registers
   logic [aosf_pkg::CFG_W-1:0]      depth_ff, extra_ff, count_ff;
   logic [aosf_pkg::CSR_DATA_W-1:0] chan_lo_ff, chan_hi_ff;

   // filter state
   logic [aosf_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [aosf_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [aosf_pkg::SLOT_W-1:0] slot_ff, slot_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           res_valid_ff;
   logic [aosf_pkg::VALUE_W-1:0]   res_value_ff;
   logic [aosf_pkg::SLOT_W-1:0]    res_slot_ff;
   logic                           done_ff;
   logic [aosf_pkg::CHAN_W-1:0]    next_chan_ff;

   // datapath signals
   logic                           accept;
   logic [aosf_pkg::CFG_W-1:0]     depth_eff, count_eff, shift;
   logic [aosf_pkg::CNT_W-1:0]     target;
   logic [aosf_pkg::ACC_W-1:0]     acc_sum, acc_shifted;
   logic [aosf_pkg::CNT_W-1:0]     cnt_sum;
   logic                           hit, last_slot;
   logic [aosf_pkg::CHAN_W-1:0]    chan_tab [aosf_pkg::MAX_SLOTS];

   // handshakes
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= aosf_pkg::DEPTH_RST;
         extra_ff   <= aosf_pkg::EXTRA_RST;
         count_ff   <= aosf_pkg::COUNT_RST;
         chan_lo_ff <= '0;
         chan_hi_ff <= '0;
      end else if (csr_valid) begin
         case (aosf_pkg::cfg_index_type'(csr_index))
            aosf_pkg::CFG_DEPTH:   depth_ff   <= csr_data[aosf_pkg::CFG_W-1:0];
            aosf_pkg::CFG_EXTRA:   extra_ff   <= csr_data[aosf_pkg::CFG_W-1:0];
            aosf_pkg::CFG_COUNT:   count_ff   <= csr_data[aosf_pkg::CFG_W-1:0];
            aosf_pkg::CFG_CHAN_LO: chan_lo_ff <= csr_data;
            aosf_pkg::CFG_CHAN_HI: chan_hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp depth and slot count into their legal ranges
   always_comb begin
      if (depth_ff < aosf_pkg::DEPTH_MIN) begin
         depth_eff = aosf_pkg::DEPTH_MIN;
      end else if (depth_ff > aosf_pkg::DEPTH_MAX) begin
         depth_eff = aosf_pkg::DEPTH_MAX;
      end else begin
         depth_eff = depth_ff;
      end
      if (count_ff == '0) begin
         count_eff = aosf_pkg::CFG_W'(1);
      end else if (count_ff > aosf_pkg::CFG_W'(aosf_pkg::MAX_SLOTS)) begin
         count_eff = aosf_pkg::CFG_W'(aosf_pkg::MAX_SLOTS);
      end else begin
         count_eff = count_ff;
      end
   end

   // accumulate and decide whether this sample closes the slot
   assign target    = aosf_pkg::CNT_W'(1) << depth_eff;
   assign acc_sum   = acc_ff + aosf_pkg::ACC_W'(req_tdata[aosf_pkg::SAMPLE_W-1:0]);
   assign cnt_sum   = cnt_ff + aosf_pkg::CNT_W'(1);
   assign hit       = (cnt_sum >= target);
   assign shift     = (extra_ff >= depth_eff) ? '0 : depth_eff - extra_ff;
   assign acc_shifted = acc_sum >> shift;

   // wrap when the slot just finished is at or past the last configured one
   assign last_slot = ({1'b0, slot_ff} + aosf_pkg::CFG_W'(1)) >= count_eff;

   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (hit) begin
            acc_in  = '0;
            cnt_in  = '0;
            slot_in = last_slot ? '0 : slot_ff + aosf_pkg::SLOT_W'(1);
         end else begin
            acc_in  = acc_sum;
            cnt_in  = cnt_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         slot_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         slot_ff <= slot_in;
      end
   end

   // channel number per slot, five bits each across the two table words
   always_comb begin
      for (int i = 0; i < aosf_pkg::SLOTS_PER_WORD; i++) begin
         chan_tab[i] = chan_lo_ff[i*aosf_pkg::CHAN_W +: aosf_pkg::CHAN_W];
         chan_tab[i + aosf_pkg::SLOTS_PER_WORD] =
            chan_hi_ff[i*aosf_pkg::CHAN_W +: aosf_pkg::CHAN_W];
      end
   end

   // response register: loads on accept, holds while stalled
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_valid_ff <= hit;
         res_value_ff <= hit ? acc_shifted[aosf_pkg::VALUE_W-1:0] : '0;
         res_slot_ff  <= hit ? slot_ff : '0;
         done_ff      <= hit && last_slot;
         next_chan_ff <= chan_tab[slot_in];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = res_valid_ff;
   assign rsp_tlast  = done_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, next_chan_ff, res_slot_ff, res_value_ff};

endmodule

`default_nettype wire

>>> sv/aosf_checker.sv
// Port-level checker for the ADC oversampling scan filter, bound to the top level.
// Depends on aosf_pkg and adc_oversample_scan_filter.
`default_nettype none

module aosf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [aosf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);

   localparam int RES_W = aosf_pkg::VALUE_W + aosf_pkg::SLOT_W;

   // the output register is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // scan completion only comes with a filtered value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("scan done without a result");

   // without a filtered value, value and slot read as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RES_W-1:0] == '0)
      else $error("result fields not cleared");

   // a stalled response transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // a full output register that is not drained blocks new samples
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("sample taken while response stalled");

endmodule

bind adc_oversample_scan_filter aosf_checker u_aosf_checker (.*);

`default_nettype wire
